[src/rxlrb_pkg.sv]
// Package for the receive line ring buffer: request and status codes,
// character constants and field widths. No dependencies.
package rxlrb_pkg;

	localparam int BYTE_W        = 8;
	localparam int STATUS_W      = 3;
	localparam int FILL_W        = 6;
	localparam int WALK_W        = 6;
	localparam int DEFAULT_DEPTH = 64;
	localparam int MAX_DATA_OUT  = 63;

	localparam logic [BYTE_W-1:0] CHAR_NUL = 8'd0;
	localparam logic [BYTE_W-1:0] CHAR_LF  = 8'd10;
	localparam logic [BYTE_W-1:0] CHAR_CR  = 8'd13;
	localparam logic [BYTE_W-1:0] CNT_MAX  = 8'd255;

	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_LINE  = 2'd2;
	localparam logic [1:0] REQ_FLUSH = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DATA     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LINE_END = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_LINE  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_DONE     = 3'd5;

endpackage

[src/rx_line_ring_buffer_top.sv]
// Receive line ring buffer top level: request decode, ring indices, line
// count and result register around one rxlrb_ram. Depends on rxlrb_pkg.
//
// A push, pop or flush is accepted and issues the RAM read of the oldest
// slot; the result is then loaded into the output register once that
// register is free. A line read loads one result per data byte and then a
// terminator, since the walk reads the RAM through its single read port,
// one slot per cycle while the output register is not stalled. A new item
// is accepted in the cycle after the last result of the previous one is
// loaded, even while that result is still waiting in the output register.
// The ring holds DEPTH-1 bytes; no clearing pass is needed after reset.
module rx_line_ring_buffer_top #(
	parameter int DEPTH = rxlrb_pkg::DEFAULT_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [1:0]                         req_type,
	input  logic [rxlrb_pkg::BYTE_W-1:0]       in_byte,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [rxlrb_pkg::BYTE_W-1:0]       out_byte,
	output logic [rxlrb_pkg::STATUS_W-1:0]     status,
	output logic                               last,
	output logic [rxlrb_pkg::BYTE_W-1:0]       lines_pending,
	output logic [rxlrb_pkg::FILL_W-1:0]       fill_level
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = (AW + 1 > rxlrb_pkg::FILL_W) ? AW + 1 : rxlrb_pkg::FILL_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic                              state_q, state_d;
	logic [1:0]                        req_q;
	logic [rxlrb_pkg::BYTE_W-1:0]      byte_q;
	logic [AW-1:0]                     wr_idx_q, wr_idx_d;
	logic [AW-1:0]                     rd_idx_q, rd_idx_d;
	logic [rxlrb_pkg::BYTE_W-1:0]      line_cnt_q, line_cnt_d;
	logic [rxlrb_pkg::WALK_W-1:0]      walk_cnt_q, walk_cnt_d;

	logic                              rsp_valid_q;
	logic [rxlrb_pkg::BYTE_W-1:0]      out_byte_q;
	logic [rxlrb_pkg::STATUS_W-1:0]    status_q;
	logic                              last_q;
	logic [rxlrb_pkg::BYTE_W-1:0]      lines_q;
	logic [rxlrb_pkg::FILL_W-1:0]      fill_q;

	logic                              accept;
	logic                              out_free;
	logic                              emit;
	logic [rxlrb_pkg::BYTE_W-1:0]      res_byte;
	logic [rxlrb_pkg::STATUS_W-1:0]    res_status;
	logic                              res_last;
	logic [AW-1:0]                     nxt_w, nxt_r;
	logic                              ring_empty;

	logic                              ram_we;
	logic                              ram_re;
	logic [AW-1:0]                     ram_raddr;
	logic [rxlrb_pkg::BYTE_W-1:0]      ram_rdata;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	// Bytes held, taken modulo 2**FILL_W.
	function automatic logic [rxlrb_pkg::FILL_W-1:0] fill_of(
		input logic [AW-1:0] w,
		input logic [AW-1:0] r
	);
		logic [FW-1:0] f;
		if (w >= r) begin
			f = FW'(w) - FW'(r);
		end else begin
			f = FW'(DEPTH) - FW'(r) + FW'(w);
		end
		return f[rxlrb_pkg::FILL_W-1:0];
	endfunction

	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign nxt_w      = next_slot(wr_idx_q);
	assign nxt_r      = next_slot(rd_idx_q);
	assign ring_empty = (wr_idx_q == rd_idx_q);

	always_comb begin
		state_d    = state_q;
		wr_idx_d   = wr_idx_q;
		rd_idx_d   = rd_idx_q;
		line_cnt_d = line_cnt_q;
		walk_cnt_d = walk_cnt_q;
		emit       = 1'b0;
		res_byte   = rxlrb_pkg::CHAR_NUL;
		res_status = rxlrb_pkg::ST_DONE;
		res_last   = 1'b1;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = nxt_r;

		if (state_q == S_IDLE) begin
			// oldest byte is fetched on accept, ready for pop or line read
			ram_re     = accept;
			walk_cnt_d = '0;
			if (accept) begin
				state_d = S_RUN;
			end
		end else if (out_free) begin
			emit    = 1'b1;
			state_d = S_IDLE;
			case (req_q)
				rxlrb_pkg::REQ_PUSH: begin
					if (nxt_w == rd_idx_q) begin
						wr_idx_d   = rd_idx_q;
						res_status = rxlrb_pkg::ST_OVERFLOW;
					end else if (byte_q != rxlrb_pkg::CHAR_NUL &&
					             byte_q != rxlrb_pkg::CHAR_LF) begin
						ram_we   = 1'b1;
						wr_idx_d = nxt_w;
						if (byte_q == rxlrb_pkg::CHAR_CR &&
						    line_cnt_q != rxlrb_pkg::CNT_MAX) begin
							line_cnt_d = line_cnt_q + 1'b1;
						end
					end
				end
				rxlrb_pkg::REQ_POP: begin
					if (ring_empty) begin
						res_status = rxlrb_pkg::ST_EMPTY;
					end else begin
						rd_idx_d   = nxt_r;
						res_byte   = ram_rdata;
						res_status = rxlrb_pkg::ST_DATA;
					end
				end
				rxlrb_pkg::REQ_LINE: begin
					if (line_cnt_q == '0) begin
						res_status = rxlrb_pkg::ST_NO_LINE;
					end else if (ring_empty ||
					             walk_cnt_q == rxlrb_pkg::WALK_W'(rxlrb_pkg::MAX_DATA_OUT)) begin
						line_cnt_d = line_cnt_q - 1'b1;
						res_status = rxlrb_pkg::ST_LINE_END;
					end else begin
						rd_idx_d = nxt_r;
						if (ram_rdata == rxlrb_pkg::CHAR_CR) begin
							// CR is consumed, only the terminator goes out
							line_cnt_d = line_cnt_q - 1'b1;
							res_status = rxlrb_pkg::ST_LINE_END;
						end else begin
							res_byte   = ram_rdata;
							res_status = rxlrb_pkg::ST_DATA;
							res_last   = 1'b0;
							walk_cnt_d = walk_cnt_q + 1'b1;
							ram_re     = 1'b1;
							ram_raddr  = next_slot(nxt_r);
							state_d    = S_RUN;
						end
					end
				end
				rxlrb_pkg::REQ_FLUSH: begin
					wr_idx_d = rd_idx_q;
				end
				default: begin
					wr_idx_d = rd_idx_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			line_cnt_q  <= '0;
			walk_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			wr_idx_q   <= wr_idx_d;
			rd_idx_q   <= rd_idx_d;
			line_cnt_q <= line_cnt_d;
			walk_cnt_q <= walk_cnt_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			byte_q <= in_byte;
		end
		if (emit) begin
			out_byte_q <= res_byte;
			status_q   <= res_status;
			last_q     <= res_last;
			lines_q    <= line_cnt_d;
			fill_q     <= fill_of(wr_idx_d, rd_idx_d);
		end
	end

	rxlrb_ram #(
		.WIDTH (rxlrb_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (nxt_w),
		.wdata (byte_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rsp_valid     = rsp_valid_q;
	assign out_byte      = out_byte_q;
	assign status        = status_q;
	assign last          = last_q;
	assign lines_pending = lines_q;
	assign fill_level    = fill_q;

endmodule

[src/rxlrb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on rxlrb_pkg for default widths.
module rxlrb_ram #(
	parameter int WIDTH = rxlrb_pkg::BYTE_W,
	parameter int DEPTH = rxlrb_pkg::DEFAULT_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
